// ----- design/itp_pkg.sv -----
// Shared types, codes and helper functions for the infix to postfix converter.
// No dependencies; imported by every module of the block but itp_ram.
`default_nettype none

package itp_pkg;

    // Symbol codes held on the stack
    localparam logic [2:0] SYM_ADD    = 3'd0;
    localparam logic [2:0] SYM_SUB    = 3'd1;
    localparam logic [2:0] SYM_MUL    = 3'd2;
    localparam logic [2:0] SYM_DIV    = 3'd3;
    localparam logic [2:0] SYM_LPAREN = 3'd4;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_INVALID  = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;
    localparam logic [1:0] STAT_UNMATCH  = 2'd3;

    // Character codes
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_D0     = 8'h30;
    localparam logic [7:0] CH_D9     = 8'h39;

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } t_state;

    // Command from the sequencer to the stack
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [2:0] code;
    } t_stk_cmd;

    // One result transaction
    typedef struct packed {
        logic       valid;
        logic [7:0] out_char;
        logic       is_char;
        logic       last;
        logic [1:0] status;
    } t_res;

    function automatic logic [7:0] sym_char(input logic [2:0] code);
        logic [7:0] c;
        case (code)
            SYM_ADD: c = CH_PLUS;
            SYM_SUB: c = CH_MINUS;
            SYM_MUL: c = CH_STAR;
            SYM_DIV: c = CH_SLASH;
            default: c = CH_LPAREN;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] sym_prec(input logic [2:0] code);
        logic [1:0] p;
        case (code)
            SYM_ADD, SYM_SUB: p = 2'd1;
            SYM_MUL, SYM_DIV: p = 2'd2;
            default:          p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- design/itp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module itp_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- design/itp_stack.sv -----
// Symbol stack: fill count, cached top entry and the backing RAM.
// Depends on itp_pkg and itp_ram.
`default_nettype none

module itp_stack
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire t_stk_cmd                         i_cmd,
    output logic      [$clog2(STACK_DEPTH+1)-1:0] o_count,
    output logic      [2:0]                       o_top
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] rd_ptr;
    logic [2:0]    r_top;
    logic [2:0]    rd_data;

    // Next fill count
    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    // Keep the entry below the top prefetched so a pop refills the top at once
    assign rd_ptr = n_count - CW'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top <= i_cmd.code;
        end else if (i_cmd.pop) begin
            r_top <= rd_data;
        end
    end

    itp_ram #(
        .WIDTH (3),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_cmd.code),
        .i_raddr (rd_ptr[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign o_count = r_count;
    assign o_top   = r_top;

endmodule

`default_nettype wire

// ----- design/itp_ctrl.sv -----
// Sequencer: classifies the held character, one stack step a cycle unless stalled.
// Depends on itp_pkg.
`default_nettype none

module itp_ctrl
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic [7:0]                       i_ch,
    input  wire logic                             i_end_of_expr,
    input  wire logic                             i_emit_ok,
    input  wire logic [$clog2(STACK_DEPTH+1)-1:0] i_count,
    input  wire logic [2:0]                       i_top,
    output logic                                  o_busy,
    output t_stk_cmd                              o_cmd,
    output t_res                                  o_res
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_state     r_state, n_state;
    logic       r_err, n_err;
    logic [7:0] r_ch;
    logic       r_end;
    logic       empty, full, is_alnum, is_op, pop_ok;
    logic [2:0] op_code;

    assign empty = (i_count == '0);
    assign full  = (i_count == CW'(STACK_DEPTH));

    always_comb begin
        is_alnum = (r_ch inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ], [CH_D0:CH_D9]});
        is_op    = 1'b1;
        case (r_ch)
            CH_PLUS:  op_code = SYM_ADD;
            CH_MINUS: op_code = SYM_SUB;
            CH_STAR:  op_code = SYM_MUL;
            CH_SLASH: op_code = SYM_DIV;
            default: begin
                op_code = SYM_ADD;
                is_op   = 1'b0;
            end
        endcase
        // Shared precedence compare against the top of stack
        pop_ok = !empty && (i_top != SYM_LPAREN) && (sym_prec(op_code) <= sym_prec(i_top));
    end

    always_comb begin
        n_state = r_state;
        n_err   = r_err;
        o_cmd   = '0;
        o_res   = '0;
        o_res.status = STAT_OK;
        o_cmd.code   = op_code;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_WORK;
                end
            end
            ST_WORK: begin
                if (i_emit_ok) begin
                    if (r_end) begin
                        if (!r_err && !empty) begin
                            o_cmd.pop        = 1'b1;
                            o_res.valid      = 1'b1;
                            o_res.is_char    = 1'b1;
                            o_res.out_char   = sym_char(i_top);
                        end else begin
                            o_cmd.clear = 1'b1;
                            o_res.valid = 1'b1;
                            o_res.last  = 1'b1;
                            n_err       = 1'b0;
                            n_state     = ST_IDLE;
                        end
                    end else if (r_err) begin
                        n_state = ST_IDLE;
                    end else if (is_alnum) begin
                        o_res.valid    = 1'b1;
                        o_res.is_char  = 1'b1;
                        o_res.out_char = r_ch;
                        n_state        = ST_IDLE;
                    end else if (r_ch == CH_LPAREN) begin
                        n_state = ST_IDLE;
                        if (full) begin
                            o_cmd.clear  = 1'b1;
                            o_res.valid  = 1'b1;
                            o_res.status = STAT_OVERFLOW;
                            n_err        = 1'b1;
                        end else begin
                            o_cmd.push = 1'b1;
                            o_cmd.code = SYM_LPAREN;
                        end
                    end else if (r_ch == CH_RPAREN) begin
                        if (empty) begin
                            o_cmd.clear  = 1'b1;
                            o_res.valid  = 1'b1;
                            o_res.status = STAT_UNMATCH;
                            n_err        = 1'b1;
                            n_state      = ST_IDLE;
                        end else begin
                            o_cmd.pop = 1'b1;
                            if (i_top == SYM_LPAREN) begin
                                n_state = ST_IDLE;
                            end else begin
                                o_res.valid    = 1'b1;
                                o_res.is_char  = 1'b1;
                                o_res.out_char = sym_char(i_top);
                            end
                        end
                    end else if (is_op) begin
                        if (pop_ok) begin
                            o_cmd.pop      = 1'b1;
                            o_res.valid    = 1'b1;
                            o_res.is_char  = 1'b1;
                            o_res.out_char = sym_char(i_top);
                        end else if (full) begin
                            o_cmd.clear  = 1'b1;
                            o_res.valid  = 1'b1;
                            o_res.status = STAT_OVERFLOW;
                            n_err        = 1'b1;
                            n_state      = ST_IDLE;
                        end else begin
                            o_cmd.push = 1'b1;
                            n_state    = ST_IDLE;
                        end
                    end else begin
                        o_cmd.clear  = 1'b1;
                        o_res.valid  = 1'b1;
                        o_res.status = STAT_INVALID;
                        n_err        = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
        end
    end

    // Hold the accepted transaction while it is worked on
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_ch  <= i_ch;
            r_end <= i_end_of_expr;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// ----- design/infix_to_postfix_converter_unit.sv -----
// Top level of the infix to postfix converter: sequencer, symbol stack, output register.
// Depends on itp_pkg, itp_ctrl, itp_stack and itp_ram.
//
// Usage:
//   Input channel (i_valid / o_stall, fields i_ch, i_end_of_expr) takes one
//   character, or the end marker, per transaction. Output channel
//   (o_valid / i_stall) gives postfix characters, error items and the
//   terminator (o_last) in order, one per transaction.
//   Work starts the cycle after acceptance; each working cycle pops one stack entry,
//   pushes one or emits one result, while the output register can take a result.
//   An operator pops and emits each stacked operator of equal or higher precedence
//   above the nearest '(' and then pushes itself; ')' pops down to its '('; the end
//   marker flushes the stack and then gives the terminator. The single stack RAM
//   port pair and one precedence compare allow one stack step at a time; o_stall
//   is high while at work. A result appears in the cycle after it is produced.
//   Receiver stall: results sit in the output register; while it is full
//   and stalled the sequencer waits, holding its place.
//   Reset (synchronous, active low): empties the stack, clears the error
//   hold and the output valid. Stack RAM contents are not cleared and
//   need no clearing pass.
`default_nettype none

module infix_to_postfix_converter_unit
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_end_of_expr,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_char,
    output logic            o_is_char,
    output logic            o_last,
    output logic [1:0]      o_status
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_stk_cmd      stk_cmd;
    t_res          res;
    logic [CW-1:0] stk_count;
    logic [2:0]    stk_top;
    logic          busy;
    logic          emit_ok;
    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic          r_is_char;
    logic          r_last;
    logic [1:0]    r_status;

    // Output register may take a new result when empty or being drained
    assign emit_ok = !r_out_valid || !i_stall;

    itp_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_ch          (i_ch),
        .i_end_of_expr (i_end_of_expr),
        .i_emit_ok     (emit_ok),
        .i_count       (stk_count),
        .i_top         (stk_top),
        .o_busy        (busy),
        .o_cmd         (stk_cmd),
        .o_res         (res)
    );

    itp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .o_count (stk_count),
        .o_top   (stk_top)
    );

    // Load a fresh result, or drop the valid once the receiver has taken it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out_char <= res.out_char;
            r_is_char  <= res.is_char;
            r_last     <= res.last;
            r_status   <= res.status;
        end
    end

    assign o_stall    = busy;
    assign o_valid    = r_out_valid;
    assign o_out_char = r_out_char;
    assign o_is_char  = r_is_char;
    assign o_last     = r_last;
    assign o_status   = r_status;

endmodule

`default_nettype wire

// ----- design/itp_checker.sv -----
// Port-level checks for the infix to postfix converter, bound to the top level.
// Depends on itp_pkg and infix_to_postfix_converter_unit.
`default_nettype none

module itp_checker
    import itp_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_out_char,
    input wire logic       o_is_char,
    input wire logic       o_last,
    input wire logic [1:0] o_status
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_char) && $stable(o_is_char)
            && $stable(o_last) && $stable(o_status))
        else $error("stalled result changed");

    // Terminator carries no character and an ok status
    a_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !o_is_char && o_status == STAT_OK && o_out_char == 8'h00)
        else $error("malformed terminator");

    // Error items are neither characters nor terminators
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STAT_OK |-> !o_is_char && !o_last && o_out_char == 8'h00)
        else $error("malformed error item");

    // Character items are ok and never last
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_char |-> o_status == STAT_OK && !o_last)
        else $error("malformed character item");

    // Reset empties the output
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind infix_to_postfix_converter_unit itp_checker u_itp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_out_char (o_out_char),
    .o_is_char  (o_is_char),
    .o_last     (o_last),
    .o_status   (o_status)
);

`default_nettype wire

// ----- tb/sv/tb_infix_to_postfix_converter_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for infix_to_postfix_converter_unit: shunting-yard conversion,
// error items, flush on the end marker, stack overflow and output back-pressure.
// Depends on itp_pkg and the converter RTL; needs no files or arguments.

module tb_infix_to_postfix_converter_unit;
    import itp_pkg::*;

    localparam int STACK_DEPTH    = 32;
    localparam int RANDOM_ITEMS   = 300;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;

    // Character emitted for each stacked symbol code, indexed by code
    localparam logic [7:0] STACKED_CHAR [0:4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                                  CH_LPAREN};
    localparam logic [7:0] OP_CHARS [0:3] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

    typedef struct packed {
        logic [7:0] out_char;
        logic       is_char;
        logic       last;
        logic [1:0] status;
    } t_postfix_item;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY
    } t_stall_mode;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_ch = 8'h00;
    logic       i_end_of_expr = 1'b0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_char;
    logic       o_is_char;
    logic       o_last;
    logic [1:0] o_status;

    // Results the converter still owes, oldest first
    t_postfix_item pending_postfix[$];

    // Shadow of the converter's operator stack
    logic [2:0] op_stack [STACK_DEPTH];
    int         op_fill = 0;
    bit         dropping_expr = 1'b0;
    int         deepest_fill = 0;

    int  mismatches = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  terminators_seen = 0;
    int  error_items_seen = 0;
    int  burst_left = 0;
    bit  hold_req = 1'b0;
    int  holds_done = 0;

    infix_to_postfix_converter_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_ch         (i_ch),
        .i_end_of_expr(i_end_of_expr),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_char   (o_out_char),
        .o_is_char    (o_is_char),
        .o_last       (o_last),
        .o_status     (o_status)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void owe_result(logic [7:0] c, logic is_char, logic last,
                                       logic [1:0] status);
        t_postfix_item item;
        item.out_char = c;
        item.is_char  = is_char;
        item.last     = last;
        item.status   = status;
        pending_postfix.push_back(item);
    endfunction

    // Emit the error item, empty the stack and drop the rest of the expression
    function automatic void abandon_expr(logic [1:0] status);
        owe_result(8'h00, 1'b0, 1'b0, status);
        op_fill = 0;
        dropping_expr = 1'b1;
    endfunction

    function automatic void push_symbol(logic [2:0] code);
        op_stack[op_fill] = code;
        op_fill++;
        if (op_fill > deepest_fill)
            deepest_fill = op_fill;
    endfunction

    function automatic int op_rank(logic [2:0] code);
        return (code == SYM_MUL || code == SYM_DIV) ? 2 : 1;
    endfunction

    function automatic bit is_alnum(logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) ||
               (c >= CH_D0 && c <= CH_D9);
    endfunction

    // Work out the results one accepted transaction causes
    function automatic void convert_postfix_char(logic [7:0] c, logic end_mark);
        logic [2:0] code;
        logic [2:0] top;
        if (end_mark) begin
            if (!dropping_expr) begin
                while (op_fill > 0) begin
                    op_fill--;
                    owe_result(STACKED_CHAR[op_stack[op_fill]], 1'b1, 1'b0, STAT_OK);
                end
            end
            op_fill = 0;
            dropping_expr = 1'b0;
            owe_result(8'h00, 1'b0, 1'b1, STAT_OK);
            return;
        end
        if (dropping_expr)
            return;
        if (is_alnum(c)) begin
            owe_result(c, 1'b1, 1'b0, STAT_OK);
            return;
        end
        if (c == CH_LPAREN) begin
            if (op_fill >= STACK_DEPTH)
                abandon_expr(STAT_OVERFLOW);
            else
                push_symbol(SYM_LPAREN);
            return;
        end
        if (c == CH_RPAREN) begin
            while (op_fill > 0) begin
                op_fill--;
                top = op_stack[op_fill];
                if (top == SYM_LPAREN)
                    return;
                owe_result(STACKED_CHAR[top], 1'b1, 1'b0, STAT_OK);
            end
            abandon_expr(STAT_UNMATCH);
            return;
        end
        case (c)
            CH_PLUS:  code = SYM_ADD;
            CH_MINUS: code = SYM_SUB;
            CH_STAR:  code = SYM_MUL;
            CH_SLASH: code = SYM_DIV;
            default: begin
                abandon_expr(STAT_INVALID);
                return;
            end
        endcase
        // Pop operators that bind at least as tightly, stopping at an open bracket
        while (op_fill > 0 && op_stack[op_fill - 1] != SYM_LPAREN &&
               op_rank(op_stack[op_fill - 1]) >= op_rank(code)) begin
            op_fill--;
            owe_result(STACKED_CHAR[op_stack[op_fill]], 1'b1, 1'b0, STAT_OK);
        end
        if (op_fill >= STACK_DEPTH)
            abandon_expr(STAT_OVERFLOW);
        else
            push_symbol(code);
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one transaction and hold it until accepted. Valid stays high on return so
    // that a following transaction in the same burst goes out back to back.
    task automatic send_item(input logic [7:0] c, input logic end_mark);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_ch          <= c;
        i_end_of_expr <= end_mark;
        do @(posedge i_clk); while (o_stall);
        convert_postfix_char(c, end_mark);
        items_sent++;
    endtask

    // Send a whole expression followed by the end marker; the marker carries a
    // random character, which the block must ignore
    task automatic send_expr(input string s);
        for (int n = 0; n < s.len(); n++)
            send_item(s[n], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Drop valid and wait for every owed result to arrive
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_postfix.size() != 0);
    endtask

    function automatic logic [7:0] random_operand();
        case ($urandom_range(0, 2))
            0:       return CH_LA + 8'($urandom_range(0, 25));
            1:       return CH_UA + 8'($urandom_range(0, 25));
            default: return CH_D0 + 8'($urandom_range(0, 9));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: random stall patterns plus a requested long hold-off
    // ------------------------------------------------------------------

    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          hold_left = 0;

    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
            holds_done++;
        end
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            mode_left  = $urandom_range(16, 96);
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            case (stall_mode)
                STALL_NONE:  i_stall <= 1'b0;
                STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                default:     i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_postfix_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_postfix.size() == 0) begin
                $error("result with nothing owed: out_char 0x%0h is_char %0b last %0b status %0d",
                       o_out_char, o_is_char, o_last, o_status);
                mismatches++;
            end else begin
                want = pending_postfix.pop_front();
                compare_field("out_char", want.out_char, o_out_char);
                compare_field("is_char", 8'(want.is_char), 8'(o_is_char));
                compare_field("last", 8'(want.last), 8'(o_last));
                compare_field("status", 8'(want.status), 8'(o_status));
                if (want.last)
                    terminators_seen++;
                if (want.status != STAT_OK)
                    error_items_seen++;
            end
        end
    end

    // Give up if nothing moves on either channel for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no transaction for %0d cycles, %0d results still owed",
                 WATCHDOG_LIMIT, pending_postfix.size());
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Range ends of every operand class, all four operators, brackets, precedence,
    // and an empty expression that yields the terminator alone
    task automatic test_operands_and_precedence();
        send_expr("(a+Z)*0-9/z");
        send_expr("A-b*c");
        send_expr("");
    endtask

    // Bytes next to each operand range, plus both ends of the byte range; the
    // character after the bad one must be dropped
    task automatic test_invalid_characters();
        logic [7:0] bad [0:6];
        bad = '{8'h00, 8'hFF, CH_LA - 8'd1, CH_LZ + 8'd1, CH_UA - 8'd1, CH_UZ + 8'd1,
                CH_D9 + 8'd1};
        foreach (bad[n]) begin
            send_item(CH_LA, 1'b0);
            send_item(bad[n], 1'b0);
            send_item(CH_D9, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // Unmatched close bracket after popping, on an empty stack, and a leftover
    // open bracket that the end marker flushes out as a character
    task automatic test_bracket_cases();
        send_expr("a+b)c");
        send_expr(")");
        send_expr("(a+b");
    endtask

    // Fill the stack exactly and flush it (the longest run of results), then push
    // one bracket and one operator past the top
    task automatic test_stack_overflow();
        repeat (STACK_DEPTH) send_item(CH_LPAREN, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        repeat (STACK_DEPTH) send_item(CH_LPAREN, 1'b0);
        send_item(CH_LPAREN, 1'b0);
        send_item(CH_LA, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        repeat (STACK_DEPTH) send_item(CH_LPAREN, 1'b0);
        send_item(CH_PLUS, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Hold the receiver off while the sender keeps offering; the block must fill
    // its output and stall the input channel
    task automatic test_receiver_hold_off();
        hold_req = 1'b1;
        send_expr("a*b+c*(d-e)/f-g+h*i-j");
        send_expr("x/(y+z)*w");
    endtask

    // Mostly well-formed expressions with random operands, operators and nesting;
    // some get stray bytes, stray brackets or a missing tail. A few nest deeply
    // enough to overflow the stack.
    task automatic test_random_expressions();
        int  target;
        int  len;
        int  depth;
        int  nest_cap;
        int  open_pct;
        bit  noisy;
        bit  want_operand;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            noisy = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) begin
                len      = $urandom_range(30, 60);
                nest_cap = STACK_DEPTH + 2;
                open_pct = 75;
            end else begin
                len      = $urandom_range(1, 16);
                nest_cap = 6;
                open_pct = 25;
            end
            depth        = 0;
            want_operand = 1'b1;
            for (int n = 0; n < len; n++) begin
                if (noisy && $urandom_range(0, 7) == 0) begin
                    case ($urandom_range(0, 2))
                        0:       send_item(8'($urandom_range(0, 255)), 1'b0);
                        1:       send_item(CH_RPAREN, 1'b0);
                        default: send_item(OP_CHARS[$urandom_range(0, 3)], 1'b0);
                    endcase
                end else if (want_operand) begin
                    if (depth < nest_cap && $urandom_range(0, 99) < open_pct) begin
                        send_item(CH_LPAREN, 1'b0);
                        depth++;
                    end else begin
                        send_item(random_operand(), 1'b0);
                        want_operand = 1'b0;
                    end
                end else if (depth > 0 && $urandom_range(0, 2) == 0) begin
                    send_item(CH_RPAREN, 1'b0);
                    depth--;
                end else begin
                    send_item(OP_CHARS[$urandom_range(0, 3)], 1'b0);
                    want_operand = 1'b1;
                end
            end
            // Close the expression properly unless this one is meant to be broken
            if (!noisy || $urandom_range(0, 1) == 0) begin
                if (want_operand)
                    send_item(random_operand(), 1'b0);
                while (depth > 0) begin
                    send_item(CH_RPAREN, 1'b0);
                    depth--;
                end
            end
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_operands_and_precedence();
        wait_drained();
        test_invalid_characters();
        wait_drained();
        test_bracket_cases();
        wait_drained();
        test_stack_overflow();
        wait_drained();
        test_receiver_hold_off();
        wait_drained();
        test_random_expressions();
        wait_drained();

        // Let any late or surplus result show itself
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d transactions in, %0d results out, %0d terminators, %0d error items.",
                 items_sent, results_seen, terminators_seen, error_items_seen);
        $display("Deepest stack fill %0d of %0d; long receiver hold-offs: %0d.",
                 deepest_fill, STACK_DEPTH, holds_done);
        if (mismatches == 0 && pending_postfix.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
